// File: hw/rtl/abft_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// abft_pkg: shared types and constants for the audio byte FIFO throttle
// Ring geometry, opcode and register codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package abft_pkg;

	localparam int RING_DEPTH = 32768;
	localparam int ADDR_W     = $clog2(RING_DEPTH);
	localparam int CNT_W      = $clog2(RING_DEPTH + 1);
	localparam int FILL_W     = 16;
	localparam int MARK_W     = 16;
	localparam int QUEUED_W   = 16;
	localparam int TOTAL_W    = ((CNT_W > QUEUED_W) ? CNT_W : QUEUED_W) + 1;

	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 32;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 16;

	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_POP  = 2'd1,
		OP_POLL = 2'd2,
		OP_NOP  = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HIGH_MARK = 1'b0,
		REG_LOW_MARK  = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_LOAD
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture; // latch the input beat
		logic exec;    // apply the operation to the ring and throttle
		logic load;    // fill the output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free; // output register empty or draining this cycle
	} status_t;

endpackage : abft_pkg
`default_nettype wire

// File: hw/rtl/audio_byte_fifo_watermark_throttle.sv
`default_nettype none
// ----------------------------------------------------------------------------
// audio_byte_fifo_watermark_throttle: byte ring with producer throttle
// Opcode-driven audio byte FIFO (push, pop, poll) with hysteresis watermarks.
// ----------------------------------------------------------------------------
// Usage
//  - Slave stream s_*: one beat per operation (push a byte, pop a byte, poll
//    the throttle with the downstream queued count, or no-op).
//  - Master stream m_*: exactly one result beat per input beat, in order:
//    popped byte, underrun / refused flags, fill level, producer_allowed.
//  - Config port: cfg_we/cfg_idx/cfg_wdata write high_mark (0) or low_mark (1);
//    only write while no item is in flight.
//  - Timing: a beat is taken in the idle state, executed the next cycle
//    (memory write or registered read of the 32768-byte store), and its result
//    loaded into the output register once that register is free. No new beat
//    is taken until the result has loaded, set by the capture / execute / load
//    sequence around the single memory port.
//  - Stall: the result register holds while m_tready is low; the controller
//    waits in its load step and takes no new beat until the result moves.
//  - Reset: indices, fill count and throttle clear, marks return to 24576 and
//    12288. The byte store is not cleared; a pop only reads written bytes.
// ----------------------------------------------------------------------------
module audio_byte_fifo_watermark_throttle (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// opcode[1:0], data_in[9:2], downstream_queued[25:10], zero[31:26]
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	input  wire logic [abft_pkg::IN_TDATA_W-1:0]      s_tdata,
	// data_out[7:0], underrun[8], write_refused[9], fill_level[25:10],
	// producer_allowed[26], zero[31:27]
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	output logic [abft_pkg::OUT_TDATA_W-1:0]          m_tdata,
	input  wire logic                                 cfg_we,
	input  wire logic [abft_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  wire logic [abft_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
	import abft_pkg::*;

	cmd_t    cmd;
	status_t status;

	// sequencer: idle -> execute -> load
	abft_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// ring, throttle and result register
	abft_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.in_tdata   (s_tdata),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.out_tvalid (m_tvalid),
		.out_tready (m_tready),
		.out_tdata  (m_tdata)
	);

	// one beat in flight: no accept straight after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("beat accepted while previous item in flight");

	// fill never exceeds the ring depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[25:10] <= 16'(RING_DEPTH)))
		else $error("fill level above ring depth");

	// an underrun reports silence and cannot coincide with a refusal
	a_underrun_silence: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[8]) |-> ((m_tdata[7:0] == 8'h00) && !m_tdata[9]))
		else $error("underrun with non-zero data or refusal");

	// a new result only loads once the previous one has gone
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result overwritten while stalled");

endmodule : audio_byte_fifo_watermark_throttle
`default_nettype wire

// File: hw/rtl/abft_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// abft_ctrl: item sequencer
// Steps each beat through capture, execute and result load.
// ----------------------------------------------------------------------------
module abft_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire abft_pkg::status_t status,
	output abft_pkg::cmd_t         cmd
);
	import abft_pkg::*;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt   = state_q;
		s_tready    = 1'b0;
		cmd         = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_nxt   = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec  = 1'b1;
				state_nxt = ST_LOAD;
			end
			ST_LOAD: begin
				if (status.out_free) begin
					cmd.load  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule : abft_ctrl
`default_nettype wire

// File: hw/rtl/abft_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// abft_dp: ring store, indices, fill count, throttle and output register
// Single-port-write / single-read byte memory with registered read data.
// ----------------------------------------------------------------------------
module abft_dp (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire abft_pkg::cmd_t                       cmd,
	output abft_pkg::status_t                         status,
	input  wire logic [abft_pkg::IN_TDATA_W-1:0]      in_tdata,
	input  wire logic                                 cfg_we,
	input  wire logic [abft_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  wire logic [abft_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	output logic                                      out_tvalid,
	input  wire logic                                 out_tready,
	output logic [abft_pkg::OUT_TDATA_W-1:0]          out_tdata
);
	import abft_pkg::*;

	logic [7:0] mem [RING_DEPTH];

	// captured beat
	op_t                 op_q;
	logic [7:0]          din_q;
	logic [QUEUED_W-1:0] queued_q;

	// ring state
	logic [ADDR_W-1:0] rd_idx_q, wr_idx_q;
	logic [CNT_W-1:0]  held_q;
	logic              throttled_q;
	logic [MARK_W-1:0] high_mark_q, low_mark_q;

	// per-item flags and read data
	logic       under_q, refused_q, pop_ok_q;
	logic [7:0] rd_data_q;

	// output register
	logic             out_valid_q;
	logic [7:0]       o_data_q;
	logic             o_under_q, o_refused_q, o_allowed_q;
	logic [FILL_W-1:0] o_fill_q;

	logic              full, empty, mem_we, mem_re;
	logic [TOTAL_W-1:0] total;
	logic [FILL_W-1:0]  fill_sat;

	function automatic logic [ADDR_W-1:0] advance(input logic [ADDR_W-1:0] idx);
		return (idx == ADDR_W'(RING_DEPTH - 1)) ? '0 : idx + 1'b1;
	endfunction

	assign full   = (held_q == CNT_W'(RING_DEPTH));
	assign empty  = (held_q == '0);
	assign mem_we = cmd.exec && (op_q == OP_PUSH) && !full;
	assign mem_re = cmd.exec && (op_q == OP_POP) && !empty;
	assign total  = TOTAL_W'(held_q) + TOTAL_W'(queued_q);
	assign fill_sat = (TOTAL_W'(held_q) > TOTAL_W'({FILL_W{1'b1}})) ?
		{FILL_W{1'b1}} : FILL_W'(held_q);

	assign status.out_free = !out_valid_q || out_tready;

	// beat capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= op_t'(in_tdata[1:0]);
			din_q    <= in_tdata[9:2];
			queued_q <= in_tdata[25:10];
		end
	end

	// byte store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_idx_q] <= din_q;
		end
		if (mem_re) begin
			rd_data_q <= mem[rd_idx_q];
		end
	end

	// flags for the current item
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			under_q   <= (op_q == OP_POP) && empty;
			refused_q <= (op_q == OP_PUSH) && full;
			pop_ok_q  <= mem_re;
		end
	end

	// ring state, throttle and marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q    <= '0;
			wr_idx_q    <= '0;
			held_q      <= '0;
			throttled_q <= 1'b0;
			high_mark_q <= MARK_W'(24576);
			low_mark_q  <= MARK_W'(12288);
		end else begin
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_idx))
					REG_HIGH_MARK: high_mark_q <= cfg_wdata;
					REG_LOW_MARK:  low_mark_q  <= cfg_wdata;
					default: ;
				endcase
			end
			if (mem_we) begin
				wr_idx_q <= advance(wr_idx_q);
				held_q   <= held_q + 1'b1;
			end
			if (mem_re) begin
				rd_idx_q <= advance(rd_idx_q);
				held_q   <= held_q - 1'b1;
			end
			if (cmd.exec && (op_q == OP_POLL) && (high_mark_q != '0)) begin
				if (throttled_q) begin
					if (total <= TOTAL_W'(low_mark_q)) begin
						throttled_q <= 1'b0;
					end
				end else if (total >= TOTAL_W'(high_mark_q)) begin
					throttled_q <= 1'b1;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			o_data_q    <= pop_ok_q ? rd_data_q : 8'h00;
			o_under_q   <= under_q;
			o_refused_q <= refused_q;
			o_fill_q    <= fill_sat;
			o_allowed_q <= (high_mark_q == '0) || !throttled_q;
		end
	end

	assign out_tvalid = out_valid_q;
	assign out_tdata  = {5'b0, o_allowed_q, o_fill_q, o_refused_q, o_under_q, o_data_q};

endmodule : abft_dp
`default_nettype wire

// File: tb/sv/audio_byte_fifo_watermark_throttle_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// audio_byte_fifo_watermark_throttle_test: self-checking bench for the byte ring
// Streams push/pop/poll/no-op beats into the ring. Each accepted beat runs
// through an independent predictor of the ring, fill count and hysteresis
// throttle. Every result beat is checked field by field against the oldest
// prediction. Covers a directed corner pass and random traffic under several
// watermark settings. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module audio_byte_fifo_watermark_throttle_test;
	import abft_pkg::*;

	localparam int          SETTLE      = 6;     // cycles after the last result
	localparam int          IDLE_LIMIT  = 4000;  // cycles without any beat
	localparam int          MAX_LINES   = 40;    // mismatch lines printed
	localparam int          SEG_COUNT   = 8;
	localparam int          SEG_ITEMS   = 250;
	localparam bit [15:0]   HIGH_RESET  = 16'd24576;
	localparam bit [15:0]   LOW_RESET   = 16'd12288;

	// one predicted result beat
	typedef struct packed {
		bit [7:0]        data_out;
		bit              underrun;
		bit              refused;
		bit [FILL_W-1:0] fill;
		bit              allowed;
	} ring_result_t;

	// Scoreboard: mirrors the ring and throttle, holds the predicted beats.
	class ring_scoreboard;
		bit [7:0]        ring_mem [RING_DEPTH];
		bit [ADDR_W-1:0] rd_ptr;
		bit [ADDR_W-1:0] wr_ptr;
		bit [FILL_W-1:0] held;
		bit              throttled;
		bit [MARK_W-1:0] high_mark;
		bit [MARK_W-1:0] low_mark;
		ring_result_t    pending [$];
		int unsigned     err_count;
		int unsigned     beat_count;

		function new();
			rd_ptr     = '0;
			wr_ptr     = '0;
			held       = '0;
			throttled  = 1'b0;
			high_mark  = HIGH_RESET;
			low_mark   = LOW_RESET;
			err_count  = 0;
			beat_count = 0;
		endfunction

		function void set_mark(reg_idx_t idx, bit [MARK_W-1:0] value);
			if (idx == REG_HIGH_MARK) high_mark = value;
			else low_mark = value;
		endfunction

		// accepted input beat: apply it and queue the result it must give
		function void note_beat(op_t op, bit [7:0] din, bit [QUEUED_W-1:0] queued);
			ring_result_t     r;
			bit [TOTAL_W-1:0] total;
			r = '0;
			case (op)
			OP_PUSH: begin
				if (held >= RING_DEPTH) begin
					r.refused = 1'b1;
				end else begin
					ring_mem[wr_ptr] = din;
					wr_ptr++;            // wraps at the ring depth
					held++;
				end
			end
			OP_POP: begin
				if (held == 0) begin
					r.underrun = 1'b1;
				end else begin
					r.data_out = ring_mem[rd_ptr];
					rd_ptr++;
					held--;
				end
			end
			OP_POLL: begin
				total = TOTAL_W'(held) + TOTAL_W'(queued);
				// hysteresis: set at high mark, clear at low mark or below;
				// a zero high mark freezes the state
				if (high_mark != 0) begin
					if (throttled) begin
						if (total <= low_mark) throttled = 1'b0;
					end else if (total >= high_mark) begin
						throttled = 1'b1;
					end
				end
			end
			default: ;
			endcase
			r.fill    = held;
			r.allowed = (high_mark == 0) || !throttled;
			pending.push_back(r);
		endfunction

		task report(string what, int unsigned got, int unsigned want);
			err_count++;
			if (err_count <= MAX_LINES)
				$display("result beat %0d: %s is %0d, expected %0d", beat_count, what, got, want);
		endtask

		task check_beat(logic [OUT_TDATA_W-1:0] beat);
			ring_result_t want;
			if (pending.size() == 0) begin
				report("unexpected beat, tdata", beat, 0);
			end else begin
				want = pending.pop_front();
				if (beat[7:0] !== want.data_out)    report("data_out", beat[7:0], want.data_out);
				if (beat[8] !== want.underrun)      report("underrun", beat[8], want.underrun);
				if (beat[9] !== want.refused)       report("write_refused", beat[9], want.refused);
				if (beat[25:10] !== want.fill)      report("fill_level", beat[25:10], want.fill);
				if (beat[26] !== want.allowed)      report("producer_allowed", beat[26], want.allowed);
			end
			beat_count++;
		endtask
	endclass

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    s_tvalid  = 1'b0;
	logic                    s_tready;
	logic [IN_TDATA_W-1:0]   s_tdata   = '0;
	logic                    m_tvalid;
	logic                    m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0]  m_tdata;
	logic                    cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_idx   = '0;
	logic [CFG_DATA_W-1:0]   cfg_wdata = '0;

	ring_scoreboard sb;
	bit             calm        = 1'b0;  // both sides run without idling
	int unsigned    quiet_cycles = 0;
	int unsigned    stall_left  = 0;

	// watermark pairs for the random segments (high, low)
	bit [15:0] seg_high [SEG_COUNT] = '{16'd24576, 16'd0, 16'd16, 16'd32768,
		16'd20, 16'd1, 16'd0, 16'd200};
	bit [15:0] seg_low  [SEG_COUNT] = '{16'd12288, 16'd0, 16'd8, 16'd32768,
		16'd40, 16'd0, 16'd0, 16'd50};

	audio_byte_fifo_watermark_throttle dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always #10 clk = ~clk;

	// idle length: mostly short, a few long
	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 75) return $urandom_range(3, 1);
		if (r < 95) return $urandom_range(12, 4);
		return $urandom_range(40, 20);
	endfunction

	// sink side: random back-pressure, none while calm
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (!calm && $urandom_range(99) < 20) begin
			m_tready   <= 1'b0;
			stall_left <= gap_len() - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// beat monitor: predict on input beats, check on output beats
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_beat(op_t'(s_tdata[1:0]), s_tdata[9:2], s_tdata[25:10]);
			if (m_tvalid && m_tready)
				sb.check_beat(m_tdata);
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		wait (quiet_cycles >= IDLE_LIMIT);
		$display("audio_byte_fifo_watermark_throttle_test: errors");
		$finish;
	end

	// one input beat, with an optional random gap in front
	task automatic send(op_t op, bit [7:0] din, bit [QUEUED_W-1:0] queued);
		int unsigned gap;
		gap = (!calm && $urandom_range(99) < 30) ? gap_len() : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			s_tdata  <= $urandom;  // junk while not valid
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, queued, din, op};
		do @(posedge clk); while (!s_tready);
	endtask

	// hold the source until every predicted beat has come back, then settle
	task automatic drain_and_settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// both marks in back-to-back writes; only called with the block idle
	task automatic write_marks(bit [MARK_W-1:0] hi, bit [MARK_W-1:0] lo);
		cfg_we    <= 1'b1;
		cfg_idx   <= REG_HIGH_MARK;
		cfg_wdata <= hi;
		@(posedge clk);
		cfg_idx   <= REG_LOW_MARK;
		cfg_wdata <= lo;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.set_mark(REG_HIGH_MARK, hi);
		sb.set_mark(REG_LOW_MARK, lo);
	endtask

	// random op; poll counts mostly aimed around the marks so the throttle flips
	task automatic random_item();
		int unsigned     pick;
		int              aim;
		op_t             op;
		bit [QUEUED_W-1:0] queued;
		pick = $urandom_range(99);
		if (pick < 40)      op = OP_PUSH;
		else if (pick < 75) op = OP_POP;
		else if (pick < 95) op = OP_POLL;
		else                op = OP_NOP;
		pick = $urandom_range(99);
		if (pick < 35)      aim = int'(sb.high_mark);
		else if (pick < 65) aim = int'(sb.low_mark);
		else                aim = -1;
		if (aim >= 0) begin
			aim = aim - int'(sb.held) + int'($urandom_range(6)) - 3;
			queued = (aim < 0) ? 16'd0 : (aim > 65535) ? 16'hFFFF : 16'(aim);
		end else if (pick < 90) begin
			queued = 16'($urandom_range(65535));
		end else begin
			queued = pick[0] ? 16'hFFFF : 16'h0000;
		end
		send(op, 8'($urandom_range(255)), queued);
	endtask

	initial begin : stimulus
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// --- directed corners, reset marks 24576 / 12288 ---
		send(OP_POP,  8'h00, 16'h0000);     // empty ring: underrun
		send(OP_NOP,  8'hFF, 16'hFFFF);     // unused opcode, status only
		send(OP_POLL, 8'hFF, 16'h0000);
		send(OP_PUSH, 8'h00, 16'hFFFF);
		send(OP_PUSH, 8'hFF, 16'h0000);
		send(OP_PUSH, 8'hA5, 16'h0000);
		send(OP_POP,  8'hFF, 16'hFFFF);
		send(OP_POP,  8'h00, 16'h0000);
		send(OP_POP,  8'h00, 16'h0000);
		send(OP_POP,  8'h00, 16'h0000);     // drained again: underrun
		send(OP_PUSH, 8'h5A, 16'h0000);
		send(OP_POLL, 8'h00, 16'hFFFF);     // far above high: throttle on
		send(OP_POLL, 8'h00, 16'd12288);    // one above low: stays on
		send(OP_POLL, 8'h00, 16'd12287);    // exactly low: off
		send(OP_POLL, 8'h00, 16'd24575);    // exactly high: on
		// throttle disabled while set: state frozen, producer allowed
		drain_and_settle();
		write_marks(16'd0, LOW_RESET);
		send(OP_POLL, 8'h00, 16'h0000);
		send(OP_POLL, 8'h00, 16'hFFFF);
		// re-enabled at the extremes: the frozen state shows again
		drain_and_settle();
		write_marks(16'd32768, 16'd0);
		send(OP_NOP,  8'h00, 16'h0000);
		send(OP_POLL, 8'h00, 16'h0000);     // total 1 > low 0: stays on
		send(OP_POP,  8'h00, 16'h0000);
		send(OP_POLL, 8'h00, 16'h0000);     // total 0: off
		send(OP_POLL, 8'h00, 16'd32767);
		send(OP_POLL, 8'h00, 16'd32768);    // on at the top mark
		// inverted marks used as written: each poll at 150 flips the state
		drain_and_settle();
		write_marks(16'd100, 16'd200);
		send(OP_POLL, 8'h00, 16'd150);
		send(OP_POLL, 8'h00, 16'd150);
		send(OP_NOP,  8'h00, 16'h0000);

		// --- random traffic over several watermark pairs ---
		for (int seg = 0; seg < SEG_COUNT; seg++) begin
			drain_and_settle();
			if (seg == 6)
				write_marks(16'($urandom_range(32768)), 16'($urandom_range(32768)));
			else
				write_marks(seg_high[seg], seg_low[seg]);
			calm <= (seg == 3);
			for (int k = 0; k < SEG_ITEMS; k++) begin
				if ($urandom_range(99) < 2) drain_and_settle();
				random_item();
			end
		end

		drain_and_settle();
		if (sb.err_count == 0)
			$display("audio_byte_fifo_watermark_throttle_test: clean");
		else
			$display("audio_byte_fifo_watermark_throttle_test: errors");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/abft_pkg.sv
hw/rtl/abft_ctrl.sv
hw/rtl/abft_dp.sv
hw/rtl/audio_byte_fifo_watermark_throttle.sv
tb/sv/audio_byte_fifo_watermark_throttle_test.sv
